### hdl/key_string_base32_decoder_unit_assert.svh
// ----------------------------------------------------------------------------
// key string base32 decoder assertion macros
// shared concurrent assertion forms, clocked on clk
// ----------------------------------------------------------------------------
`ifndef KEY_STRING_BASE32_DECODER_UNIT_ASSERT_SVH
`define KEY_STRING_BASE32_DECODER_UNIT_ASSERT_SVH

// checked out of reset only
`define KSB32_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define KSB32_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/ksb32_pkg.sv
// ----------------------------------------------------------------------------
// ksb32_pkg
// types, constants and lookup functions for the key string base32 decoder
// ----------------------------------------------------------------------------
package ksb32_pkg;

    localparam int unsigned DATA_CHARS = 52;
    localparam logic [5:0] KEY_BYTES = 6'd32;
    localparam logic [6:0] PUB_PLEN = 7'd4;
    localparam logic [6:0] SEC_PLEN = 7'd16;
    localparam logic [6:0] PUB_TOTAL = PUB_PLEN + 7'(DATA_CHARS);
    localparam logic [6:0] SEC_TOTAL = SEC_PLEN + 7'(DATA_CHARS);
    localparam logic [6:0] POS_MAX = 7'd127;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_FORMAT = 2'd1,
        STATUS_WEAK   = 2'd2
    } status_t;

    // one input word held in the input register
    typedef struct packed {
        logic       valid;
        logic [7:0] char_code;
        logic       is_last;
    } item_t;

    // one result word
    typedef struct packed {
        logic       present;
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       done_res;
        status_t    status;
    } result_t;

    // alphabet map: bit 5 set for a code outside the alphabet
    function automatic logic [5:0] symbol_value(input logic [7:0] c);
        logic [5:0] v;
        begin
            case (c)
                "q": v = 6'd0;   "p": v = 6'd1;   "z": v = 6'd2;   "r": v = 6'd3;
                "y": v = 6'd4;   "9": v = 6'd5;   "x": v = 6'd6;   "8": v = 6'd7;
                "g": v = 6'd8;   "f": v = 6'd9;   "2": v = 6'd10;  "t": v = 6'd11;
                "v": v = 6'd12;  "d": v = 6'd13;  "w": v = 6'd14;  "0": v = 6'd15;
                "s": v = 6'd16;  "3": v = 6'd17;  "j": v = 6'd18;  "n": v = 6'd19;
                "5": v = 6'd20;  "4": v = 6'd21;  "k": v = 6'd22;  "h": v = 6'd23;
                "c": v = 6'd24;  "e": v = 6'd25;  "6": v = 6'd26;  "m": v = 6'd27;
                "u": v = 6'd28;  "a": v = 6'd29;  "7": v = 6'd30;  "l": v = 6'd31;
                default: v = 6'd32;
            endcase
            return v;
        end
    endfunction

    // public key prefix character
    function automatic logic [7:0] pub_prefix_char(input logic [1:0] idx);
        logic [7:0] ch;
        begin
            case (idx)
                2'd0: ch = "a";
                2'd1: ch = "g";
                2'd2: ch = "e";
                default: ch = "1";
            endcase
            return ch;
        end
    endfunction

    // secret key prefix character
    function automatic logic [7:0] sec_prefix_char(input logic [3:0] idx);
        logic [7:0] ch;
        begin
            case (idx)
                4'd0:  ch = "A";
                4'd1:  ch = "G";
                4'd2:  ch = "E";
                4'd3:  ch = "-";
                4'd4:  ch = "S";
                4'd5:  ch = "E";
                4'd6:  ch = "C";
                4'd7:  ch = "R";
                4'd8:  ch = "E";
                4'd9:  ch = "T";
                4'd10: ch = "-";
                4'd11: ch = "K";
                4'd12: ch = "E";
                4'd13: ch = "Y";
                4'd14: ch = "-";
                default: ch = "1";
            endcase
            return ch;
        end
    endfunction

endpackage

### hdl/ksb32_in_stage.sv
// ----------------------------------------------------------------------------
// ksb32_in_stage
// input register; takes a new word when empty or whenever the held one moves on
// ----------------------------------------------------------------------------
module ksb32_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  logic [7:0]     s_axis_tdata,   // [7:0] char_code
    input  logic           s_axis_tlast,   // is_last
    input  logic           advance,
    output ksb32_pkg::item_t item
);
    import ksb32_pkg::*;

    logic       valid_reg;
    logic [7:0] char_reg;
    logic       last_reg;

    assign s_axis_tready = !valid_reg || advance;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_axis_tvalid && s_axis_tready)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            char_reg <= s_axis_tdata;
            last_reg <= s_axis_tlast;
        end
    end

    assign item.valid     = valid_reg;
    assign item.char_code = char_reg;
    assign item.is_last   = last_reg;

endmodule

### hdl/ksb32_decode.sv
// ----------------------------------------------------------------------------
// ksb32_decode
// per-string state and the single-pass character decode
// ----------------------------------------------------------------------------
module ksb32_decode (
    input  logic               clk,
    input  logic               rst_n,
    input  ksb32_pkg::item_t   item,
    input  logic               advance,
    input  logic               key_kind,
    output ksb32_pkg::result_t result
);
    import ksb32_pkg::*;

    logic [6:0]  pos_reg, pos_next;
    logic [11:0] acc_reg, acc_next;
    logic [2:0]  pend_reg, pend_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        fe_reg, fe_next;
    logic        nz_reg, nz_next;

    // decode of the held character
    always_comb
    begin
        logic [6:0] plen;
        logic [6:0] total;
        logic [5:0] sym;
        logic [3:0] pend_sum;
        logic [7:0] exp_char;
        logic [7:0] byte_val;
        logic       have_byte;
        begin
            plen      = key_kind ? SEC_PLEN : PUB_PLEN;
            total     = key_kind ? SEC_TOTAL : PUB_TOTAL;
            exp_char  = key_kind ? sec_prefix_char(pos_reg[3:0])
                                 : pub_prefix_char(pos_reg[1:0]);
            sym       = symbol_value(item.char_code);
            pend_sum  = 4'(pend_reg) + 4'd5;
            byte_val  = 8'd0;
            have_byte = 1'b0;

            acc_next  = acc_reg;
            pend_next = pend_reg;
            cnt_next  = cnt_reg;
            fe_next   = fe_reg;
            nz_next   = nz_reg;
            pos_next  = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 7'd1;

            // prefix, length and alphabet checks, then bit regrouping
            if (pos_reg >= total)
            begin
                fe_next = 1'b1;
            end
            else if (pos_reg < plen)
            begin
                if (item.char_code != exp_char)
                begin
                    fe_next = 1'b1;
                end
            end
            else if (!fe_reg)
            begin
                if (sym[5])
                begin
                    fe_next = 1'b1;
                end
                else
                begin
                    acc_next = {acc_reg[6:0], sym[4:0]};
                    if (pend_sum >= 4'd8)
                    begin
                        pend_next = 3'(pend_sum - 4'd8);
                        byte_val  = acc_next[pend_next +: 8];
                        have_byte = 1'b1;
                        cnt_next  = cnt_reg + 6'd1;
                        if (byte_val != 8'd0)
                        begin
                            nz_next = 1'b1;
                        end
                    end
                    else
                    begin
                        pend_next = pend_sum[2:0];
                    end
                end
            end

            // early or late end of string
            if (item.is_last && (({1'b0, pos_reg} + 8'd1) != {1'b0, total}))
            begin
                fe_next = 1'b1;
            end
            if (fe_next)
            begin
                have_byte = 1'b0;
            end

            result.present    = have_byte || item.is_last;
            result.data_byte  = have_byte ? byte_val : 8'd0;
            result.byte_valid = have_byte;
            result.done_res   = item.is_last;
            if (!item.is_last)
            begin
                result.status = STATUS_OK;
            end
            else if (fe_next || (cnt_next != KEY_BYTES))
            begin
                result.status = STATUS_FORMAT;
            end
            else if (!key_kind && !nz_next)
            begin
                result.status = STATUS_WEAK;
            end
            else
            begin
                result.status = STATUS_OK;
            end

            // string finished: back to the start
            if (item.is_last)
            begin
                pos_next  = 7'd0;
                acc_next  = 12'd0;
                pend_next = 3'd0;
                cnt_next  = 6'd0;
                fe_next   = 1'b0;
                nz_next   = 1'b0;
            end
        end
    end

    // string state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= 7'd0;
            acc_reg  <= 12'd0;
            pend_reg <= 3'd0;
            cnt_reg  <= 6'd0;
            fe_reg   <= 1'b0;
            nz_reg   <= 1'b0;
        end
        else if (advance)
        begin
            pos_reg  <= pos_next;
            acc_reg  <= acc_next;
            pend_reg <= pend_next;
            cnt_reg  <= cnt_next;
            fe_reg   <= fe_next;
            nz_reg   <= nz_next;
        end
    end

endmodule

### hdl/key_string_base32_decoder_unit.sv
// A character taken into the input register is decoded combinationally; its result word,
// if any, is loaded into the result register when the held word moves on and offered from there.
// Throughput: one character per cycle; the single decode pass between the input
// register and the result register sets that figure. A result word held by the
// master side also holds the input register, so stalls pass straight back.
// Reset: rst_n clears both valid flags, the string state and key_kind to public.
// ----------------------------------------------------------------------------
// key_string_base32_decoder_unit
// key string base32 decoder: prefix check, alphabet map and byte regrouping
// ----------------------------------------------------------------------------
`include "key_string_base32_decoder_unit_assert.svh"

module key_string_base32_decoder_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,        // key_kind
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,    // [7:0] char_code
    input  logic       s_axis_tlast,    // is_last
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,    // [7:0] data_byte
    output logic [2:0] m_axis_tuser,    // [0] byte_valid, [2:1] status
    output logic       m_axis_tlast     // done_res
);
    import ksb32_pkg::*;

    item_t      in_item;
    result_t    res;
    logic       advance;
    logic       key_kind_reg;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_bv_reg;
    logic       out_done_reg;
    status_t    out_status_reg;

    // held word moves on when the result register is free or being drained
    assign advance = in_item.valid && (!out_valid_reg || m_axis_tready);

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_kind_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            key_kind_reg <= cfg_data;
        end
    end

    ksb32_in_stage u_in_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .advance       (advance),
        .item          (in_item)
    );

    ksb32_decode u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (in_item),
        .advance  (advance),
        .key_kind (key_kind_reg),
        .result   (res)
    );

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= res.present;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_byte_reg   <= res.data_byte;
            out_bv_reg     <= res.byte_valid;
            out_done_reg   <= res.done_res;
            out_status_reg <= res.status;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tuser  = {out_status_reg, out_bv_reg};
    assign m_axis_tlast  = out_done_reg;

    // a word with no byte must close a string
    `KSB32_ASSERT(a_empty_word_is_done,
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast,
        "result word with neither byte nor done")
    // status stays ok except on the closing word
    `KSB32_ASSERT(a_status_only_on_done,
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser[2:1] == STATUS_OK,
        "status set on a word that is not done")
    // no byte goes out alongside a format error
    `KSB32_ASSERT(a_no_byte_with_format_error,
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tuser[2:1] != STATUS_FORMAT,
        "byte delivered with invalid format status")
    // a stalled full pipe takes no new word
    `KSB32_ASSERT(a_full_pipe_stalls_input,
        in_item.valid && out_valid_reg && !m_axis_tready |-> !s_axis_tready,
        "input taken while both registers are stalled")
    // no result once reset has been seen at an edge
    `KSB32_ASSERT_ALWAYS(a_quiet_in_reset,
        !rst_n |=> !m_axis_tvalid,
        "result valid during reset")

endmodule

### tb/ksb32_checker.sv
// ----------------------------------------------------------------------------
// ksb32_checker
// follows the configuration, character and result channels of the key string
// decoder, predicts each result word from the accepted characters and
// compares every field of the words that come out
// ----------------------------------------------------------------------------
module ksb32_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic       cfg_data,
    input  logic       s_axis_tvalid,
    input  logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,
    input  logic       s_axis_tlast,
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata,
    input  logic [2:0] m_axis_tuser,
    input  logic       m_axis_tlast,
    output int         fail_count,
    output int         outstanding,
    output int         results_seen
);
    import ksb32_pkg::*;

    localparam logic [8*32-1:0] ALPHABET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";
    localparam logic [8*4-1:0]  PUB_TEXT = "age1";
    localparam logic [8*16-1:0] SEC_TEXT = "AGE-SECRET-KEY-1";
    localparam int              MAX_REPORTS = 200;

    typedef struct {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       done_res;
        status_t    status;
    } decoded_t;

    decoded_t   decoded_q[$];
    decoded_t   head;

    // own copy of the register and the per-string state
    logic       key_kind_q;
    logic [6:0] char_pos;
    logic [11:0] bit_acc;
    logic [2:0] bit_pend;
    logic [5:0] byte_count;
    logic       fmt_err;
    logic       seen_nonzero;

    // position of a character in the alphabet, 32 when outside it
    function automatic int alphabet_index(input logic [7:0] c);
        int idx;
        idx = 32;
        for (int i = 31; i >= 0; i--)
            if (ALPHABET[8*(31-i) +: 8] == c)
                idx = i;
        return idx;
    endfunction

    function automatic logic [7:0] prefix_char(input logic secret, input int p);
        if (secret)
            return SEC_TEXT[8*(15-p) +: 8];
        else
            return PUB_TEXT[8*(3-p) +: 8];
    endfunction

    task automatic clear_string();
        char_pos     = '0;
        bit_acc      = '0;
        bit_pend     = '0;
        byte_count   = '0;
        fmt_err      = 1'b0;
        seen_nonzero = 1'b0;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        if (fail_count < MAX_REPORTS)
            $display("mismatch on result word %0d: %s got 0x%0h, expected 0x%0h",
                     results_seen, what, got, want);
        fail_count++;
    endtask

    // decode one accepted character and queue the word it causes, if any
    task automatic decode_char(input logic [7:0] c, input logic last);
        int         p;
        int         plen;
        int         total;
        int         sym;
        int         bits;
        logic [7:0] bval;
        logic       got_byte;
        decoded_t   w;
        p        = int'(char_pos);
        plen     = key_kind_q ? int'(SEC_PLEN) : int'(PUB_PLEN);
        total    = key_kind_q ? int'(SEC_TOTAL) : int'(PUB_TOTAL);
        got_byte = 1'b0;
        bval     = '0;
        if (char_pos != POS_MAX)
            char_pos = char_pos + 7'd1;

        // length, prefix and alphabet checks, then regroup 5-bit symbols into bytes
        if (p >= total)
            fmt_err = 1'b1;
        else if (p < plen)
        begin
            if (c != prefix_char(key_kind_q, p))
                fmt_err = 1'b1;
        end
        else if (!fmt_err)
        begin
            sym = alphabet_index(c);
            if (sym >= 32)
                fmt_err = 1'b1;
            else
            begin
                bit_acc = {bit_acc[6:0], 5'(sym)};
                bits    = int'(bit_pend) + 5;
                if (bits >= 8)
                begin
                    bits       -= 8;
                    bval        = 8'(bit_acc >> bits);
                    got_byte    = 1'b1;
                    byte_count  = byte_count + 6'd1;
                    if (bval != 8'h00)
                        seen_nonzero = 1'b1;
                end
                bit_pend = 3'(bits);
            end
        end

        if (last && p + 1 != total)
            fmt_err = 1'b1;
        if (fmt_err)
            got_byte = 1'b0;

        if (got_byte || last)
        begin
            w.data_byte  = got_byte ? bval : 8'h00;
            w.byte_valid = got_byte;
            w.done_res   = last;
            w.status     = STATUS_OK;
            if (last)
            begin
                // a format fault outranks the weak key verdict
                if (fmt_err || byte_count != KEY_BYTES)
                    w.status = STATUS_FORMAT;
                else if (!key_kind_q && !seen_nonzero)
                    w.status = STATUS_WEAK;
                clear_string();
            end
            decoded_q.push_back(w);
        end
    endtask

    // sample all three channels at the rising edge
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            key_kind_q = 1'b0;
            clear_string();
            decoded_q.delete();
            fail_count   = 0;
            results_seen = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                key_kind_q = cfg_data;

            // compare an outgoing word with the oldest prediction
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (decoded_q.size() == 0)
                    report_mismatch("word with nothing pending, data", m_axis_tdata, 0);
                else
                begin
                    head = decoded_q.pop_front();
                    if (m_axis_tdata !== head.data_byte)
                        report_mismatch("data_byte", m_axis_tdata, head.data_byte);
                    if (m_axis_tuser[0] !== head.byte_valid)
                        report_mismatch("byte_valid", m_axis_tuser[0], head.byte_valid);
                    if (m_axis_tlast !== head.done_res)
                        report_mismatch("done_res", m_axis_tlast, head.done_res);
                    if (m_axis_tuser[2:1] !== head.status)
                        report_mismatch("status", m_axis_tuser[2:1], head.status);
                end
            end

            if (s_axis_tvalid && s_axis_tready)
                decode_char(s_axis_tdata, s_axis_tlast);
        end
        outstanding = decoded_q.size();
    end

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// testbench for the key string base32 decoder: sends public and secret key
// strings, well formed and broken, under both key kinds with random gaps and
// back-pressure, while a checker module predicts and compares every word
// ----------------------------------------------------------------------------
module tb;
    import ksb32_pkg::*;

    localparam logic [8*32-1:0] ALPHABET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";
    localparam logic [8*4-1:0]  PUB_TEXT = "age1";
    localparam logic [8*16-1:0] SEC_TEXT = "AGE-SECRET-KEY-1";
    localparam logic [8*4-1:0]  OFF_ALPHABET = "bio1";
    localparam int              RANDOM_CHARS = 120;
    localparam int              CYCLE_LIMIT = 500000;

    logic       clk;
    logic       rst_n;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       cfg_data;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;
    logic       s_axis_tlast;
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;
    logic [2:0] m_axis_tuser;
    logic       m_axis_tlast;

    int         fail_count;
    int         outstanding;
    int         results_seen;

    logic [7:0] text_q[$];
    logic       kind_now;
    logic       burst_text;
    int         chars_sent;
    int         texts_sent;
    int         cfg_writes;
    int         cycle_count;
    int         random_start;
    int         ready_hold;
    logic       ready_level;

    key_string_base32_decoder_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    ksb32_checker decode_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .results_seen  (results_seen)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words still pending",
                     cycle_count, outstanding);
            $display("FAIL key_string_base32_decoder_unit");
            $finish;
        end
    end

    // result side back-pressure: open stretches, short stalls, a few long ones
    always @(negedge clk)
    begin
        if (ready_hold == 0)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    ready_level = 1'b1;
                    ready_hold  = $urandom_range(1, 40);
                end
                9:
                begin
                    ready_level = 1'b0;
                    ready_hold  = $urandom_range(10, 40);
                end
                default:
                begin
                    ready_level = 1'b0;
                    ready_hold  = $urandom_range(1, 3);
                end
            endcase
        end
        ready_hold--;
        m_axis_tready <= ready_level;
    end

    function automatic int prefix_len(input logic secret);
        return secret ? int'(SEC_PLEN) : int'(PUB_PLEN);
    endfunction

    function automatic logic [7:0] random_symbol();
        int k;
        k = $urandom_range(0, 31);
        return ALPHABET[8*k +: 8];
    endfunction

    // a character that is certainly outside the alphabet
    function automatic logic [7:0] bad_symbol();
        int k;
        k = $urandom_range(0, 3);
        case ($urandom_range(0, 3))
            0:       return 8'h80 + 8'($urandom_range(0, 127));
            1:       return 8'h41 + 8'($urandom_range(0, 25));
            2:       return OFF_ALPHABET[8*k +: 8];
            default: return 8'($urandom_range(0, 47));
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_text || r < 65)
            return 0;
        else if (r < 94)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    task automatic push_prefix(input logic secret);
        if (secret)
            for (int i = 0; i < 16; i++)
                text_q.push_back(SEC_TEXT[8*(15-i) +: 8]);
        else
            for (int i = 0; i < 4; i++)
                text_q.push_back(PUB_TEXT[8*(3-i) +: 8]);
    endtask

    task automatic push_data(input int n, input logic zero);
        repeat (n)
            text_q.push_back(zero ? 8'h71 : random_symbol());
    endtask

    // one character word, entered and left at a falling edge
    task automatic put_char(input logic [7:0] c, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_text();
        burst_text = ($urandom_range(0, 3) == 0);
        foreach (text_q[i])
            put_char(text_q[i], i == text_q.size() - 1);
        chars_sent += text_q.size();
        texts_sent++;
    endtask

    // wait for every pending word plus the pipeline depth
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_kind(input logic v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        kind_now = v;
        cfg_writes++;
    endtask

    // mostly well formed keys with random content, the rest broken or noise
    task automatic build_random_text(input logic secret);
        int r;
        int plen;
        int n;
        int at;
        r    = $urandom_range(0, 99);
        plen = prefix_len(secret);
        text_q.delete();
        if (r >= 93)
        begin
            n = $urandom_range(1, 20);
            repeat (n) text_q.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            push_prefix(r >= 88 ? !secret : secret);
            if (r < 5)
                push_data(DATA_CHARS, 1'b1);
            else if (r < 10)
            begin
                // zero key but for one symbol
                push_data(DATA_CHARS, 1'b1);
                at = $urandom_range(plen, plen + DATA_CHARS - 1);
                text_q[at] = random_symbol();
            end
            else
                push_data(DATA_CHARS, 1'b0);

            if (r >= 60 && r < 68)
            begin
                at = $urandom_range(0, plen - 1);
                text_q[at] = text_q[at] ^ 8'($urandom_range(1, 255));
            end
            else if (r >= 68 && r < 76)
            begin
                at = $urandom_range(plen, text_q.size() - 1);
                text_q[at] = bad_symbol();
            end
            else if (r >= 76 && r < 82)
            begin
                n = $urandom_range(1, text_q.size() - 1);
                text_q = text_q[0:n-1];
            end
            else if (r >= 82 && r < 88)
                push_data($urandom_range(1, 8), 1'b0);
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        ready_hold    = 0;
        ready_level   = 1'b0;
        burst_text    = 1'b0;
        kind_now      = 1'b0;
        chars_sent    = 0;
        texts_sent    = 0;
        cfg_writes    = 0;
        cycle_count   = 0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // public keys: plain, all zero, zero with set trailing bits, all ones
        write_kind(1'b0);
        text_q.delete(); push_prefix(1'b0); push_data(DATA_CHARS, 1'b0); send_text();
        text_q.delete(); push_prefix(1'b0); push_data(DATA_CHARS, 1'b1); send_text();
        text_q.delete(); push_prefix(1'b0); push_data(DATA_CHARS - 1, 1'b1);
        text_q.push_back(8'h30); send_text();
        text_q.delete(); push_prefix(1'b0);
        repeat (DATA_CHARS) text_q.push_back(8'h6c);
        send_text();

        // uppercase prefix, code zero among the data, final flag on the prefix, a lone 0xff
        text_q.delete(); push_prefix(1'b0); text_q[0] = 8'h41;
        push_data(DATA_CHARS, 1'b0); send_text();
        text_q.delete(); push_prefix(1'b0); push_data(DATA_CHARS, 1'b0);
        text_q[30] = 8'h00; send_text();
        text_q.delete(); push_prefix(1'b0); send_text();
        text_q.delete(); text_q.push_back(8'hff); send_text();

        // zero key one symbol too long: format wins over weak
        text_q.delete(); push_prefix(1'b0); push_data(DATA_CHARS + 1, 1'b1); send_text();

        // run well past the position counter's saturation
        text_q.delete(); push_prefix(1'b0); push_data(126, 1'b0); send_text();

        // secret keys: plain, all zero (no weak check), public prefix
        settle();
        write_kind(1'b1);
        text_q.delete(); push_prefix(1'b1); push_data(DATA_CHARS, 1'b0); send_text();
        text_q.delete(); push_prefix(1'b1); push_data(DATA_CHARS, 1'b1); send_text();
        text_q.delete(); push_prefix(1'b0); push_data(DATA_CHARS, 1'b0); send_text();

        // random phases, each under a freshly written key kind
        random_start = chars_sent;
        while (chars_sent - random_start < RANDOM_CHARS)
        begin
            settle();
            write_kind(1'($urandom_range(0, 1)));
            repeat ($urandom_range(1, 4))
            begin
                build_random_text(kind_now);
                send_text();
            end
        end

        settle();
        $display("sent %0d key strings, %0d characters, %0d key kind writes",
                 texts_sent, chars_sent, cfg_writes);
        $display("compared %0d result words, %0d mismatches", results_seen, fail_count);
        if (fail_count == 0 && outstanding == 0)
            $display("PASS key_string_base32_decoder_unit");
        else
            $display("FAIL key_string_base32_decoder_unit");
        $finish;
    end

endmodule
